@@ rtl/core/segint_pkg.sv @@
// Shared constants and types for the segment intersection block.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package segint_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_BITS       = 32;

    // occupancy flags of the queue between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/core/segint_in_if.sv @@
// Input channel: one beat carries the two segments' endpoints.
// Widths follow COORD_BITS; defaults from segint_pkg.
`timescale 1ns / 1ps

interface segint_in_if #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

@@ rtl/core/segint_out_if.sv @@
// Output channel: one beat carries the hit flag and the crossing point.
// Depends on segint_pkg for the point width.
`timescale 1ns / 1ps

interface segint_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [segint_pkg::OUT_BITS-1:0] cross_x;
    logic signed [segint_pkg::OUT_BITS-1:0] cross_y;

    modport source (
        output valid, hit, cross_x, cross_y,
        input  ready
    );
    modport sink (
        input  valid, hit, cross_x, cross_y,
        output ready
    );
endinterface

@@ rtl/core/segint_front.sv @@
// Front end: accepts a segment pair, forms the cross products, classifies
// the pair and scales t by each direction of B. Uses segint_pkg, segint_in_if.
`timescale 1ns / 1ps

module segint_front #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int ENTRY_BITS = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    segint_in_if.sink             in_seg,
    input  segint_pkg::q_status_t q_status,
    output logic                  push,
    output logic [ENTRY_BITS-1:0] push_data
);
    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 3;   // signed cross product
    localparam int TW = 2 * C + 2;   // magnitude of p and t on a hit
    localparam int MW = TW + C;      // t * |direction|

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   adv;

    // stage 1: differences
    logic signed [C:0]      dax_reg, day_reg, dbx_reg, dby_reg, wx_reg, wy_reg;
    logic signed [C-1:0]    bsx1_reg, bsy1_reg;
    // stage 2: cross products
    logic signed [PW-1:0]   p_reg, t_reg, s_reg;
    logic signed [C:0]      dbx2_reg, dby2_reg;
    logic signed [C-1:0]    bsx2_reg, bsy2_reg;
    // stage 3: classification and products
    logic                   hit_reg, negx_reg, negy_reg;
    logic [TW-1:0]          pa_reg;
    logic [MW-1:0]          magx_reg, magy_reg;
    logic signed [C-1:0]    bsx3_reg, bsy3_reg;

    logic signed [C:0]      dax_next, day_next, dbx_next, dby_next, wx_next, wy_next;
    logic signed [2*C+1:0]  m_pa, m_pb, m_ta, m_tb, m_sa, m_sb;
    logic signed [PW-1:0]   e_pa, e_pb, e_ta, e_tb, e_sa, e_sb;
    logic signed [PW-1:0]   p_next, t_next, s_next;
    logic signed [PW-1:0]   pa_s, ta_s, sa_s;
    logic                   hit_next;
    logic [C-1:0]           absx, absy;
    logic [MW-1:0]          magx_next, magy_next;

    // hold the whole front while its last stage waits on a full queue
    assign adv          = !v3_reg || !q_status.full;
    assign in_seg.ready = adv;
    assign push         = v3_reg && adv;
    assign push_data    = {hit_reg, negx_reg, negy_reg, pa_reg, magx_reg, magy_reg,
                           bsx3_reg, bsy3_reg};

    always_comb
    begin
        dax_next = {in_seg.a_end_x[C-1], in_seg.a_end_x}
                 - {in_seg.a_start_x[C-1], in_seg.a_start_x};
        day_next = {in_seg.a_end_y[C-1], in_seg.a_end_y}
                 - {in_seg.a_start_y[C-1], in_seg.a_start_y};
        dbx_next = {in_seg.b_end_x[C-1], in_seg.b_end_x}
                 - {in_seg.b_start_x[C-1], in_seg.b_start_x};
        dby_next = {in_seg.b_end_y[C-1], in_seg.b_end_y}
                 - {in_seg.b_start_y[C-1], in_seg.b_start_y};
        wx_next  = {in_seg.a_start_x[C-1], in_seg.a_start_x}
                 - {in_seg.b_start_x[C-1], in_seg.b_start_x};
        wy_next  = {in_seg.a_start_y[C-1], in_seg.a_start_y}
                 - {in_seg.b_start_y[C-1], in_seg.b_start_y};
    end

    always_comb
    begin
        m_pa   = dax_reg * dby_reg;
        m_pb   = day_reg * dbx_reg;
        m_ta   = dax_reg * wy_reg;
        m_tb   = day_reg * wx_reg;
        m_sa   = dbx_reg * wy_reg;
        m_sb   = dby_reg * wx_reg;
        e_pa   = PW'(m_pa);
        e_pb   = PW'(m_pb);
        e_ta   = PW'(m_ta);
        e_tb   = PW'(m_tb);
        e_sa   = PW'(m_sa);
        e_sb   = PW'(m_sb);
        p_next = e_pa - e_pb;
        t_next = e_ta - e_tb;
        s_next = e_sa - e_sb;
    end

    always_comb
    begin
        // flip signs so p is never negative
        if (p_reg < 0)
        begin
            pa_s = -p_reg;
            ta_s = -t_reg;
            sa_s = -s_reg;
        end
        else
        begin
            pa_s = p_reg;
            ta_s = t_reg;
            sa_s = s_reg;
        end
        hit_next  = (pa_s != 0) && (ta_s >= 0) && (ta_s <= pa_s)
                 && (sa_s >= 0) && (sa_s <= pa_s);
        absx      = dbx2_reg[C] ? C'(-dbx2_reg) : C'(dbx2_reg);
        absy      = dby2_reg[C] ? C'(-dby2_reg) : C'(dby2_reg);
        magx_next = ta_s[TW-1:0] * absx;
        magy_next = ta_s[TW-1:0] * absy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_seg.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dax_reg  <= dax_next;
            day_reg  <= day_next;
            dbx_reg  <= dbx_next;
            dby_reg  <= dby_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            bsx1_reg <= in_seg.b_start_x;
            bsy1_reg <= in_seg.b_start_y;

            p_reg    <= p_next;
            t_reg    <= t_next;
            s_reg    <= s_next;
            dbx2_reg <= dbx_reg;
            dby2_reg <= dby_reg;
            bsx2_reg <= bsx1_reg;
            bsy2_reg <= bsy1_reg;

            hit_reg  <= hit_next;
            negx_reg <= dbx2_reg[C];
            negy_reg <= dby2_reg[C];
            pa_reg   <= pa_s[TW-1:0];
            magx_reg <= magx_next;
            magy_reg <= magy_next;
            bsx3_reg <= bsx2_reg;
            bsy3_reg <= bsy2_reg;
        end
    end

endmodule

@@ rtl/core/segint_queue.sv @@
// Short queue that decouples the front end from the divider pipeline.
// Uses segint_pkg for depth and status type.
`timescale 1ns / 1ps

module segint_queue #(
    parameter int ENTRY_BITS = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ENTRY_BITS-1:0] push_data,
    input  logic                  pop,
    output logic [ENTRY_BITS-1:0] pop_data,
    output segint_pkg::q_status_t status
);
    localparam int DEPTH = segint_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [ENTRY_BITS-1:0] mem_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]           count_reg;

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/segint_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage for x
// and y in lockstep, then the fixed-point placement into the output register.
// Uses segint_pkg and segint_out_if.
`timescale 1ns / 1ps

module segint_back #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF,
    parameter int ENTRY_BITS = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  segint_pkg::q_status_t q_status,
    input  logic [ENTRY_BITS-1:0] pop_data,
    output logic                  pop,
    segint_out_if.source          out_seg
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int OB = segint_pkg::OUT_BITS;
    localparam int TW = 2 * C + 2;
    localparam int MW = TW + C;
    localparam int DW = MW + F;              // dividend width
    localparam int QB = C + F;               // quotient bound: |dir| * 2^F
    localparam int WW = C + F + 2;
    localparam int OW = (WW > OB) ? WW : OB;

    logic                adv;

    // queue head, unpacked
    logic                h_hit, h_negx, h_negy;
    logic [TW-1:0]       h_p;
    logic [MW-1:0]       h_magx, h_magy;
    logic [C-1:0]        h_bsx, h_bsy;

    logic                v_reg    [QB];
    logic                hit_reg  [QB];
    logic                negx_reg [QB];
    logic                negy_reg [QB];
    logic [TW-1:0]       p_reg    [QB];
    logic [DW-1:0]       remx_reg [QB];
    logic [DW-1:0]       remy_reg [QB];
    logic [QB-1:0]       qx_reg   [QB];
    logic [QB-1:0]       qy_reg   [QB];
    logic [C-1:0]        bsx_reg  [QB];
    logic [C-1:0]        bsy_reg  [QB];

    logic                out_valid_reg, out_hit_reg;
    logic [OB-1:0]       out_x_reg, out_y_reg;
    logic [OB-1:0]       px_next, py_next;

    function automatic logic [OB-1:0] place_fix(
        input logic [C-1:0]  base,
        input logic [QB-1:0] quo,
        input logic          rnz,
        input logic          neg
    );
        logic signed [WW-1:0] qo;
        logic signed [WW-1:0] bx;
        logic signed [WW-1:0] whole;
        logic signed [OW-1:0] wide;
        qo = WW'(quo);
        if (neg)
        begin
            // floor of the negative quotient
            qo = -qo - WW'(rnz);
        end
        bx    = WW'($signed(base));
        whole = (bx <<< F) + qo;
        // truncate toward zero
        if (whole < 0 && rnz)
        begin
            whole = whole + WW'(1);
        end
        wide = OW'(whole);
        return wide[OB-1:0];
    endfunction

    assign {h_hit, h_negx, h_negy, h_p, h_magx, h_magy, h_bsx, h_bsy} = pop_data;

    // one global stall for the divider; the output register is the last stage
    assign adv           = !out_valid_reg || out_seg.ready;
    assign pop           = adv && !q_status.empty;
    assign out_seg.valid = out_valid_reg;
    assign out_seg.hit   = out_hit_reg;
    assign out_seg.cross_x = out_x_reg;
    assign out_seg.cross_y = out_y_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int SH = QB - 1 - k;

        logic            v_in, hit_in, negx_in, negy_in;
        logic [TW-1:0]   p_in;
        logic [DW-1:0]   rx_in, ry_in, dvs;
        logic [QB-1:0]   qx_in, qy_in;
        logic [C-1:0]    bsx_in, bsy_in;

        if (k == 0)
        begin : g_head
            assign v_in    = pop;
            assign hit_in  = h_hit;
            assign negx_in = h_negx;
            assign negy_in = h_negy;
            assign p_in    = h_p;
            assign rx_in   = DW'(h_magx) << F;
            assign ry_in   = DW'(h_magy) << F;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign bsx_in  = h_bsx;
            assign bsy_in  = h_bsy;
        end
        else
        begin : g_mid
            assign v_in    = v_reg[k-1];
            assign hit_in  = hit_reg[k-1];
            assign negx_in = negx_reg[k-1];
            assign negy_in = negy_reg[k-1];
            assign p_in    = p_reg[k-1];
            assign rx_in   = remx_reg[k-1];
            assign ry_in   = remy_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
            assign bsx_in  = bsx_reg[k-1];
            assign bsy_in  = bsy_reg[k-1];
        end

        assign dvs = DW'(p_in) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hit_reg[k]  <= hit_in;
                negx_reg[k] <= negx_in;
                negy_reg[k] <= negy_in;
                p_reg[k]    <= p_in;
                bsx_reg[k]  <= bsx_in;
                bsy_reg[k]  <= bsy_in;
                if (rx_in >= dvs)
                begin
                    remx_reg[k] <= rx_in - dvs;
                    qx_reg[k]   <= qx_in | (QB'(1) << SH);
                end
                else
                begin
                    remx_reg[k] <= rx_in;
                    qx_reg[k]   <= qx_in;
                end
                if (ry_in >= dvs)
                begin
                    remy_reg[k] <= ry_in - dvs;
                    qy_reg[k]   <= qy_in | (QB'(1) << SH);
                end
                else
                begin
                    remy_reg[k] <= ry_in;
                    qy_reg[k]   <= qy_in;
                end
            end
        end
    end

    always_comb
    begin
        px_next = place_fix(bsx_reg[QB-1], qx_reg[QB-1], |remx_reg[QB-1], negx_reg[QB-1]);
        py_next = place_fix(bsy_reg[QB-1], qy_reg[QB-1], |remy_reg[QB-1], negy_reg[QB-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= hit_reg[QB-1];
            // drop the point on a miss
            out_x_reg   <= hit_reg[QB-1] ? px_next : '0;
            out_y_reg   <= hit_reg[QB-1] ? py_next : '0;
        end
    end

endmodule

@@ rtl/core/segment_intersection.sv @@
// Top level of the segment intersection block: front end, queue, divider.
// Uses segint_pkg, segint_in_if, segint_out_if and the segint_* modules.
`timescale 1ns / 1ps

// Takes one pair of 2-D segments per beat and returns one beat with hit and,
// on a hit, the crossing point in signed fixed point with FRAC_BITS fraction
// bits (truncated toward zero, low 32 bits kept); misses, parallel and
// collinear pairs give hit 0 and a zero point. Throughput is one pair per
// cycle while the output is not stalled. A pair passes 3 front stages, the
// queue, then COORD_BITS + FRAC_BITS divider stages (one quotient bit each)
// and the output register. A four-beat queue lets the front keep accepting
// briefly while the output is held.
module segment_intersection #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    segint_in_if.sink     seg_in,
    segint_out_if.source  seg_out
);
    localparam int TW = 2 * COORD_BITS + 2;
    localparam int MW = TW + COORD_BITS;
    localparam int EB = 3 + TW + 2 * MW + 2 * COORD_BITS;

    segint_pkg::q_status_t q_status;
    logic                  push, pop;
    logic [EB-1:0]         push_data, pop_data;

    segint_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (EB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_seg    (seg_in),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    segint_queue #(
        .ENTRY_BITS (EB)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    segint_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_BITS (EB)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .out_seg  (seg_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("queue pop while empty");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_out.valid && !seg_out.hit) |-> (seg_out.cross_x == 0 && seg_out.cross_y == 0))
        else $error("miss with nonzero point");
`endif

endmodule

@@ bench/tb_segment_intersection.sv @@
// Self-checking bench for segment_intersection: random and directed segment pairs.
// Depends on segint_pkg, segint_in_if, segint_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_segment_intersection;

    localparam int CB = segint_pkg::COORD_BITS_DEF;
    localparam int FB = segint_pkg::FRAC_BITS_DEF;
    localparam int OB = segint_pkg::OUT_BITS;

    typedef struct packed {
        logic signed [CB-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    } seg_pair_t;

    typedef struct packed {
        logic          hit;
        logic [OB-1:0] x;
        logic [OB-1:0] y;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    segint_in_if #(.COORD_BITS(CB)) seg_in();
    segint_out_if seg_out();

    segment_intersection #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .seg_in(seg_in.sink), .seg_out(seg_out.source)
    );

    always #2 clk = ~clk;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int        errors = 0;
    bit        quiet_tail = 1'b0;
    bit        feed_done = 1'b0;

    // b_start + (t/p)*dir in fixed point, truncated toward zero
    function automatic logic [OB-1:0] place_coord(longint base, longint dir, longint t,
                                                  longint p);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = (128'(signed'(base)) * p + 128'(signed'(t)) * dir) <<< FB;
        q = num / 128'(signed'(p));
        return q[OB-1:0];
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        crossing_t r;
        longint dax, day, dbx, dby, wx, wy, p, t, u;
        dax = longint'(s.aex) - s.asx;
        day = longint'(s.aey) - s.asy;
        dbx = longint'(s.bex) - s.bsx;
        dby = longint'(s.bey) - s.bsy;
        wx = longint'(s.asx) - s.bsx;
        wy = longint'(s.asy) - s.bsy;
        p = dax * dby - day * dbx;
        t = dax * wy - day * wx;
        u = dbx * wy - dby * wx;
        if (p < 0)
        begin
            p = -p;
            t = -t;
            u = -u;
        end
        r = '0;
        r.hit = p != 0 && t >= 0 && t <= p && u >= 0 && u <= p;
        if (r.hit)
        begin
            r.x = place_coord(s.bsx, dbx, t, p);
            r.y = place_coord(s.bsy, dby, t, p);
        end
        return r;
    endfunction

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t s;
        s.asx = CB'(a); s.asy = CB'(b); s.aex = CB'(c); s.aey = CB'(d);
        s.bsx = CB'(e); s.bsy = CB'(f); s.bex = CB'(g); s.bey = CB'(h);
        return s;
    endfunction

    // append a pair to the driver's list
    function automatic void add_pair(seg_pair_t s);
        pending_pairs.insert(pending_pairs.size(), s);
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 40) - 20);
            2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // driver
    int idle_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_in.valid <= 1'b0;
            seg_in.a_start_x <= '0; seg_in.a_start_y <= '0;
            seg_in.a_end_x <= '0;   seg_in.a_end_y <= '0;
            seg_in.b_start_x <= '0; seg_in.b_start_y <= '0;
            seg_in.b_end_x <= '0;   seg_in.b_end_y <= '0;
        end
        else
        begin
            if (seg_in.valid && seg_in.ready)
                expected_crossings.insert(expected_crossings.size(),
                    predict_crossing({seg_in.a_start_x,
                    seg_in.a_start_y, seg_in.a_end_x, seg_in.a_end_y, seg_in.b_start_x,
                    seg_in.b_start_y, seg_in.b_end_x, seg_in.b_end_y}));
            if (!seg_in.valid || seg_in.ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    seg_in.valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 15) == 0)
                begin
                    idle_left <= $urandom_range(0, 9);
                    seg_in.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    seg_pair_t s;
                    s = pending_pairs.pop_front();
                    seg_in.valid <= 1'b1;
                    seg_in.a_start_x <= s.asx; seg_in.a_start_y <= s.asy;
                    seg_in.a_end_x <= s.aex;   seg_in.a_end_y <= s.aey;
                    seg_in.b_start_x <= s.bsx; seg_in.b_start_y <= s.bsy;
                    seg_in.b_end_x <= s.bex;   seg_in.b_end_y <= s.bey;
                end
                else
                    seg_in.valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_out.ready <= 1'b0;
        else
        begin
            if (seg_out.valid && seg_out.ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $error("unexpected beat: hit=%0b x=%h y=%h", seg_out.hit,
                           seg_out.cross_x, seg_out.cross_y);
                    errors++;
                end
                else
                begin
                    crossing_t e;
                    e = expected_crossings.pop_front();
                    if (seg_out.hit !== e.hit)
                    begin
                        $error("hit: expected %0b actual %0b", e.hit, seg_out.hit);
                        errors++;
                    end
                    if (seg_out.cross_x !== e.x)
                    begin
                        $error("cross_x: expected %h actual %h", e.x, seg_out.cross_x);
                        errors++;
                    end
                    if (seg_out.cross_y !== e.y)
                    begin
                        $error("cross_y: expected %h actual %h", e.y, seg_out.cross_y);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                seg_out.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 9);
                seg_out.ready <= 1'b0;
            end
            else
                seg_out.ready <= 1'b1;
        end
    end

    initial
    begin
        int m;
        seg_pair_t s;
        // crossing X, parallel, collinear overlap, zero length, endpoint touch, miss, then extreme coordinates
        add_pair(mk(-10, -10, 10, 10, -10, 10, 10, -10));
        add_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
        add_pair(mk(0, 0, 10, 0, 5, 0, 15, 0));
        add_pair(mk(3, 3, 3, 3, 0, 0, 10, 10));
        add_pair(mk(0, 0, 10, 0, 10, 0, 10, 10));
        add_pair(mk(0, 0, 10, 0, 0, 0, 0, -7));
        add_pair(mk(0, 0, 1, 0, 5, -1, 5, 1));
        add_pair(mk(0, 0, 3, 1, 0, 1, 3, 0));
        add_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        add_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        add_pair(mk(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        add_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        add_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        add_pair(mk(-32768, 32767, 32767, -32767, -32767, -32768, 32766, 32767));
        add_pair(mk(-1, -1, 2, 3, 2, -1, -3, 1));
        for (int i = 0; i < 1900; i++)
        begin
            m = $urandom_range(0, 3);
            s.asx = rnd_coord(m); s.asy = rnd_coord(m);
            s.aex = rnd_coord(m); s.aey = rnd_coord(m);
            s.bsx = rnd_coord(m); s.bsy = rnd_coord(m);
            s.bex = rnd_coord(m); s.bey = rnd_coord(m);
            case ($urandom_range(0, 7))
                0: begin s.bsx = s.aex; s.bsy = s.aey; end  // shared endpoint
                1: begin s.bex = s.bsx + (s.aex - s.asx); s.bey = s.bsy + (s.aey - s.asy); end
                default: ;
            endcase
            add_pair(s);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() < 200);
        quiet_tail = 1'b1;
        wait (pending_pairs.size() == 0 && !seg_in.valid);
        wait (expected_crossings.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/segint_pkg.sv
rtl/core/segint_in_if.sv
rtl/core/segint_out_if.sv
rtl/core/segint_front.sv
rtl/core/segint_queue.sv
rtl/core/segint_back.sv
rtl/core/segment_intersection.sv
bench/tb_segment_intersection.sv
